/* rtl/opbp_pkg.sv */
// package: constants, codes and types shared by the packet buffer pool
package opbp_pkg;

   localparam int SLOTS      = 16;
   localparam int SLOT_BYTES = 64;

   localparam int SLOT_W = $clog2(SLOTS);
   localparam int LINK_W = SLOT_W + 1;
   localparam int OFF_W  = $clog2(SLOT_BYTES);
   localparam int CUR_W  = $clog2(SLOT_BYTES + 1);
   localparam int CNT_W  = $clog2(SLOTS + 1);
   localparam int ADDR_W = SLOT_W + OFF_W;
   localparam int DEPTH  = SLOTS * SLOT_BYTES;

   localparam logic [LINK_W-1:0] NIL = LINK_W'(SLOTS);

   typedef enum logic [1:0] {
      REQ_PUSH   = 2'd0,
      REQ_READ   = 2'd1,
      REQ_FREE   = 2'd2,
      REQ_STATUS = 2'd3
   } req_code_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_DISABLED = 3'd1,
      ST_NO_FREE  = 3'd2,
      ST_NO_MATCH = 3'd3,
      ST_BAD_LEN  = 3'd4,
      ST_BAD_SLOT = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      SL_FREE     = 2'd0,
      SL_FILLING  = 2'd1,
      SL_OCCUPIED = 2'd2
   } slot_state_type;

   typedef enum logic [1:0] {
      MODE_IDLE = 2'd0,
      MODE_FILL = 2'd1,
      MODE_DROP = 2'd2
   } fill_mode_type;

   localparam logic CSR_ENABLE = 1'b0;
   localparam logic CSR_ACTIVE = 1'b1;

   typedef struct packed {
      logic              we;
      logic              re;
      logic [ADDR_W-1:0] addr;
      logic [7:0]        wdata;
   } ram_req_type;

endpackage

/* rtl/opbp_ram.sv */
// packet byte store: single port synchronous ram with registered read
module opbp_ram (
   input  logic                 clock,
   input  opbp_pkg::ram_req_type ram_req,
   output logic [7:0]           ram_rdata
);
   import opbp_pkg::*;

   logic [7:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (ram_req.we) begin
         mem[ram_req.addr] <= ram_req.wdata;
      end
      if (ram_req.re) begin
         ram_rdata <= mem[ram_req.addr];
      end
   end

endmodule

/* rtl/opbp_ctrl.sv */
// controller: slot table, linked order list, request sequencer and result register
module opbp_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_enable,
   input  logic [0:0]            csr_index,
   input  logic [4:0]            csr_write_data,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [1:0]            req_type,
   input  logic [7:0]            req_data_byte,
   input  logic                  req_last_byte,
   input  logic [7:0]            req_match_byte,
   input  logic [6:0]            req_read_length,
   input  logic [3:0]            req_slot_index,
   output opbp_pkg::ram_req_type ram_req,
   input  logic [7:0]            ram_rdata,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [2:0]            rsp_status,
   output logic [7:0]            rsp_data_out,
   output logic                  rsp_last,
   output logic [3:0]            rsp_slot_out,
   output logic [6:0]            rsp_stored_length,
   output logic [4:0]            rsp_filled_count,
   output logic [4:0]            rsp_free_count,
   output logic                  rsp_first_ready,
   output logic [6:0]            rsp_first_length
);
   import opbp_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_APPEND, S_FILL, S_WALK, S_UNLINK, S_RD, S_OUT, S_EMIT
   } state_type;

   state_type      state_ff;
   slot_state_type st_ff   [SLOTS];
   logic [LINK_W-1:0] link_ff [SLOTS];
   logic [CUR_W-1:0]  len_ff  [SLOTS];
   logic [7:0]        fb_ff   [SLOTS];
   logic [LINK_W-1:0] head_ff;
   logic [SLOT_W-1:0] fslot_ff;
   logic [CUR_W-1:0]  cursor_ff;
   fill_mode_type     mode_ff;
   logic              enable_ff;
   logic [4:0]        active_ff;

   logic [LINK_W-1:0] n_ff;
   logic [SLOT_W-1:0] tgt_ff;
   logic              is_read_ff;
   logic [CUR_W-1:0]  k_ff;
   logic [6:0]        rlen_ff;
   logic [CUR_W-1:0]  slen_ff;
   status_type        ostat_ff;
   logic [SLOT_W-1:0] oslot_ff;
   logic [7:0]        byte_ff;
   logic              last_ff;
   logic [7:0]        match_ff;

   logic              rsp_valid_ff;
   logic [2:0]        rsp_status_ff;
   logic [7:0]        rsp_data_ff;
   logic              rsp_last_ff;
   logic [SLOT_W-1:0] rsp_slot_ff;
   logic [CUR_W-1:0]  rsp_slen_ff;
   logic [CNT_W-1:0]  rsp_filled_ff;
   logic [CNT_W-1:0]  rsp_free_ff;
   logic              rsp_ready_ff;
   logic [CUR_W-1:0]  rsp_flen_ff;

   logic [4:0]        act;
   logic              free_found;
   logic [SLOT_W-1:0] free_idx;
   logic [CNT_W-1:0]  filled_cnt;
   logic [CNT_W-1:0]  free_cnt;
   logic              head_ready;
   logic [CUR_W-1:0]  head_len;
   logic              out_free;
   logic              accept;
   logic [SLOT_W-1:0] n_idx;
   logic [SLOT_W-1:0] head_idx;
   logic              n_nil;
   logic              fill_room;
   logic [CUR_W-1:0]  fill_next;
   logic              stream_last;
   logic              rsp_load;
   status_type        idle_stat;
   state_type         idle_next;

   always_comb begin
      if (active_ff == 5'd0) begin
         act = 5'd1;
      end else if (active_ff > 5'(SLOTS)) begin
         act = 5'(SLOTS);
      end else begin
         act = active_ff;
      end
   end

   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      filled_cnt = '0;
      free_cnt   = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (5'(i) < act && st_ff[i] == SL_FREE) begin
            free_found = 1'b1;
            free_idx   = SLOT_W'(i);
         end
      end
      for (int i = 0; i < SLOTS; i++) begin
         if (5'(i) < act && st_ff[i] == SL_OCCUPIED) filled_cnt = filled_cnt + 1'b1;
         if (5'(i) < act && st_ff[i] == SL_FREE) free_cnt = free_cnt + 1'b1;
      end
   end

   // request decode: status and next state for an accepted beat
   always_comb begin
      idle_stat = ST_OK;
      idle_next = S_EMIT;
      if (!enable_ff) begin
         idle_stat = ST_DISABLED;
      end else begin
         unique case (req_code_type'(req_type))
            REQ_PUSH: begin
               if (mode_ff == MODE_FILL) begin
                  idle_next = S_FILL;
               end else if (mode_ff != MODE_IDLE || !free_found) begin
                  idle_stat = ST_NO_FREE;
               end else if (head_ff[SLOT_W]) begin
                  idle_next = S_FILL;
               end else begin
                  idle_next = S_APPEND;
               end
            end
            REQ_READ: begin
               if (req_read_length == 7'd0 || req_read_length > 7'(SLOT_BYTES)) begin
                  idle_stat = ST_BAD_LEN;
               end else begin
                  idle_next = S_WALK;
               end
            end
            REQ_FREE: begin
               if (5'(req_slot_index) >= act) begin
                  idle_stat = ST_BAD_SLOT;
               end else if (st_ff[req_slot_index] != SL_FREE) begin
                  idle_next = S_UNLINK;
               end
            end
            REQ_STATUS: ;
            default: ;
         endcase
      end
   end

   assign head_idx   = head_ff[SLOT_W-1:0];
   assign head_ready = !head_ff[SLOT_W] && st_ff[head_idx] == SL_OCCUPIED;
   assign head_len   = head_ready ? len_ff[head_idx] : '0;
   assign n_idx      = n_ff[SLOT_W-1:0];
   assign n_nil      = n_ff[SLOT_W];
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign rsp_load   = out_free && (state_ff == S_OUT || state_ff == S_EMIT);
   assign accept     = req_valid && state_ff == S_IDLE;
   assign req_stall  = state_ff != S_IDLE;
   assign fill_room  = cursor_ff < CUR_W'(SLOT_BYTES);
   assign fill_next  = fill_room ? cursor_ff + 1'b1 : cursor_ff;
   assign stream_last = 7'(k_ff + 1'b1) == rlen_ff;

   always_comb begin
      ram_req.we    = state_ff == S_FILL && fill_room;
      ram_req.re    = state_ff == S_RD;
      ram_req.wdata = byte_ff;
      if (state_ff == S_FILL) begin
         ram_req.addr = {fslot_ff, cursor_ff[OFF_W-1:0]};
      end else begin
         ram_req.addr = {tgt_ff, k_ff[OFF_W-1:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= NIL;
         fslot_ff     <= '0;
         cursor_ff    <= '0;
         mode_ff      <= MODE_IDLE;
         enable_ff    <= 1'b0;
         active_ff    <= 5'(SLOTS);
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < SLOTS; i++) begin
            st_ff[i]   <= SL_FREE;
            link_ff[i] <= NIL;
            len_ff[i]  <= '0;
         end
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_ENABLE: enable_ff <= csr_write_data[0];
               CSR_ACTIVE: active_ff <= csr_write_data;
               default: ;
            endcase
         end
         if (rsp_valid_ff && !rsp_stall && !rsp_load) rsp_valid_ff <= 1'b0;

         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  byte_ff    <= req_data_byte;
                  last_ff    <= req_last_byte;
                  match_ff   <= req_match_byte;
                  rlen_ff    <= req_read_length;
                  ostat_ff   <= idle_stat;
                  slen_ff    <= '0;
                  is_read_ff <= 1'b0;
                  state_ff   <= idle_next;
                  if (enable_ff && req_code_type'(req_type) == REQ_FREE &&
                      idle_stat == ST_OK) begin
                     oslot_ff <= req_slot_index;
                  end else begin
                     oslot_ff <= '0;
                  end
                  if (enable_ff) begin
                     unique case (req_code_type'(req_type))
                        REQ_PUSH: begin
                           if (mode_ff != MODE_FILL && mode_ff != MODE_IDLE) begin
                              if (req_last_byte) mode_ff <= MODE_IDLE;
                           end else if (mode_ff == MODE_IDLE && !free_found) begin
                              if (!req_last_byte) mode_ff <= MODE_DROP;
                           end else if (mode_ff == MODE_IDLE) begin
                              st_ff[free_idx]   <= SL_FILLING;
                              link_ff[free_idx] <= NIL;
                              fslot_ff          <= free_idx;
                              cursor_ff         <= '0;
                              mode_ff           <= MODE_FILL;
                              tgt_ff            <= free_idx;
                              n_ff              <= head_ff;
                              if (head_ff[SLOT_W]) head_ff <= LINK_W'(free_idx);
                           end
                        end
                        REQ_READ: begin
                           if (idle_next == S_WALK) n_ff <= head_ff;
                        end
                        REQ_FREE: begin
                           if (idle_next == S_UNLINK) begin
                              tgt_ff <= req_slot_index;
                              n_ff   <= head_ff;
                           end
                        end
                        REQ_STATUS: ;
                        default: ;
                     endcase
                  end
               end
            end
            S_APPEND: begin
               if (link_ff[n_idx] == NIL) begin
                  link_ff[n_idx] <= LINK_W'(tgt_ff);
                  state_ff       <= S_FILL;
               end else begin
                  n_ff <= link_ff[n_idx];
               end
            end
            S_FILL: begin
               oslot_ff <= fslot_ff;
               if (fill_room) begin
                  if (cursor_ff == '0) fb_ff[fslot_ff] <= byte_ff;
               end else begin
                  ostat_ff <= ST_BAD_LEN;
               end
               if (last_ff) begin
                  st_ff[fslot_ff]  <= SL_OCCUPIED;
                  len_ff[fslot_ff] <= fill_next;
                  mode_ff          <= MODE_IDLE;
                  cursor_ff        <= '0;
               end else begin
                  cursor_ff <= fill_next;
               end
               state_ff <= S_EMIT;
            end
            S_WALK: begin
               if (n_nil || st_ff[n_idx] != SL_OCCUPIED) begin
                  ostat_ff <= ST_NO_MATCH;
                  state_ff <= S_EMIT;
               end else if (fb_ff[n_idx] == match_ff) begin
                  tgt_ff     <= n_idx;
                  slen_ff    <= len_ff[n_idx];
                  is_read_ff <= 1'b1;
                  n_ff       <= head_ff;
                  state_ff   <= S_UNLINK;
               end else begin
                  n_ff <= link_ff[n_idx];
               end
            end
            S_UNLINK: begin
               if (head_ff == LINK_W'(tgt_ff) || n_nil || link_ff[n_idx] == LINK_W'(tgt_ff)) begin
                  if (head_ff == LINK_W'(tgt_ff)) begin
                     head_ff <= link_ff[tgt_ff];
                  end else if (!n_nil) begin
                     link_ff[n_idx] <= link_ff[tgt_ff];
                  end
                  link_ff[tgt_ff] <= NIL;
                  st_ff[tgt_ff]   <= SL_FREE;
                  len_ff[tgt_ff]  <= '0;
                  if (is_read_ff) begin
                     k_ff     <= '0;
                     state_ff <= S_RD;
                  end else begin
                     if (mode_ff == MODE_FILL && fslot_ff == tgt_ff) begin
                        mode_ff   <= MODE_DROP;
                        cursor_ff <= '0;
                     end
                     state_ff <= S_EMIT;
                  end
               end else begin
                  n_ff <= link_ff[n_idx];
               end
            end
            S_RD: begin
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (out_free) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= ST_OK;
                  rsp_data_ff   <= ram_rdata;
                  rsp_last_ff   <= stream_last;
                  rsp_slot_ff   <= tgt_ff;
                  rsp_slen_ff   <= slen_ff;
                  rsp_filled_ff <= filled_cnt;
                  rsp_free_ff   <= free_cnt;
                  rsp_ready_ff  <= head_ready;
                  rsp_flen_ff   <= head_len;
                  k_ff          <= k_ff + 1'b1;
                  state_ff      <= stream_last ? S_IDLE : S_RD;
               end
            end
            S_EMIT: begin
               if (out_free) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= ostat_ff;
                  rsp_data_ff   <= '0;
                  rsp_last_ff   <= 1'b1;
                  rsp_slot_ff   <= oslot_ff;
                  rsp_slen_ff   <= '0;
                  rsp_filled_ff <= filled_cnt;
                  rsp_free_ff   <= free_cnt;
                  rsp_ready_ff  <= head_ready;
                  rsp_flen_ff   <= head_len;
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_data_out      = rsp_data_ff;
   assign rsp_last          = rsp_last_ff;
   assign rsp_slot_out      = rsp_slot_ff;
   assign rsp_stored_length = 7'(rsp_slen_ff);
   assign rsp_filled_count  = 5'(rsp_filled_ff);
   assign rsp_free_count    = 5'(rsp_free_ff);
   assign rsp_first_ready   = rsp_ready_ff;
   assign rsp_first_length  = 7'(rsp_flen_ff);

endmodule

/* rtl/ordered_packet_buffer_pool_top.sv */
// top level: ordered packet buffer pool, controller plus packet byte store
// usage:
//   the req channel carries one request per beat (push byte, read with match,
//   free slot, status query); req_stall is high while a request is in work.
//   the rsp channel returns one beat per result; a read that finds a match
//   returns read_length beats, any other result exactly one beat with rsp_last set.
//   csr_write_enable with csr_index 0 writes enable, index 1 active_slots;
//   write only while the pool is idle.
//   a read walks the order list one link a cycle (up to 16), unlinks one
//   link a cycle (up to 16) and then streams its bytes, each read from the
//   single port byte store with its registered read (S_RD, then S_OUT) and
//   held in S_OUT while the result register is stalled. a push that allocates
//   a slot behind a non-empty list walks to the list tail, one link a cycle.
//   reset is synchronous: all slots free, list empty, pool disabled,
//   active_slots 16; the byte store is not cleared.
//   the result register holds a beat while rsp_stall is high; a stalled
//   result blocks the next result but not acceptance of the next request.
module ordered_packet_buffer_pool_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write_enable,
   input  logic [0:0] csr_index,
   input  logic [4:0] csr_write_data,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_type,
   input  logic [7:0] req_data_byte,
   input  logic       req_last_byte,
   input  logic [7:0] req_match_byte,
   input  logic [6:0] req_read_length,
   input  logic [3:0] req_slot_index,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [2:0] rsp_status,
   output logic [7:0] rsp_data_out,
   output logic       rsp_last,
   output logic [3:0] rsp_slot_out,
   output logic [6:0] rsp_stored_length,
   output logic [4:0] rsp_filled_count,
   output logic [4:0] rsp_free_count,
   output logic       rsp_first_ready,
   output logic [6:0] rsp_first_length
);
   import opbp_pkg::*;

   ram_req_type ram_req;
   logic [7:0]  ram_rdata;

   opbp_ctrl u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_type          (req_type),
      .req_data_byte     (req_data_byte),
      .req_last_byte     (req_last_byte),
      .req_match_byte    (req_match_byte),
      .req_read_length   (req_read_length),
      .req_slot_index    (req_slot_index),
      .ram_req           (ram_req),
      .ram_rdata         (ram_rdata),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_data_out      (rsp_data_out),
      .rsp_last          (rsp_last),
      .rsp_slot_out      (rsp_slot_out),
      .rsp_stored_length (rsp_stored_length),
      .rsp_filled_count  (rsp_filled_count),
      .rsp_free_count    (rsp_free_count),
      .rsp_first_ready   (rsp_first_ready),
      .rsp_first_length  (rsp_first_length)
   );

   opbp_ram u_ram (
      .clock     (clock),
      .ram_req   (ram_req),
      .ram_rdata (ram_rdata)
   );

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (6'(rsp_filled_count) + 6'(rsp_free_count)) <= 6'(SLOTS))
      else $error("filled plus free exceeds slot count");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_first_ready) |-> rsp_first_length == 7'd0)
      else $error("head length without a ready head");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OK) |-> rsp_last)
      else $error("error beat not marked last");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data_out != 8'd0) |-> rsp_status == ST_OK)
      else $error("data on a non-ok beat");

endmodule

/* bench/ordered_packet_buffer_pool_checker.sv */
// checker: predicts pool results from accepted requests and compares each result beat
module ordered_packet_buffer_pool_checker
   import opbp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write_enable,
   input  logic [0:0] csr_index,
   input  logic [4:0] csr_write_data,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic [1:0] req_type,
   input  logic [7:0] req_data_byte,
   input  logic       req_last_byte,
   input  logic [7:0] req_match_byte,
   input  logic [6:0] req_read_length,
   input  logic [3:0] req_slot_index,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic [2:0] rsp_status,
   input  logic [7:0] rsp_data_out,
   input  logic       rsp_last,
   input  logic [3:0] rsp_slot_out,
   input  logic [6:0] rsp_stored_length,
   input  logic [4:0] rsp_filled_count,
   input  logic [4:0] rsp_free_count,
   input  logic       rsp_first_ready,
   input  logic [6:0] rsp_first_length,
   output int         errors,
   output int         pending,
   output int         beats_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [2:0] status;
      logic [7:0] data;
      logic       last;
      logic [3:0] slot;
      logic [6:0] slen;
      logic [4:0] filled;
      logic [4:0] freec;
      logic       ready;
      logic [6:0] flen;
   } pool_beat_t;

   pool_beat_t     expected_beats[$];
   slot_state_type slot_st[SLOTS];
   logic [4:0]     slot_next[SLOTS];
   int             slot_length[SLOTS];
   int             slot_written[SLOTS];
   logic [7:0]     bytes[DEPTH];
   logic [4:0]     head;
   int             cur_slot;
   int             cursor;
   fill_mode_type  mode;
   logic           pool_en;
   logic [4:0]     active_cfg;

   assign pending = expected_beats.size();

   function automatic int active_n();
      int a;
      a = active_cfg;
      if (a < 1) a = 1;
      if (a > SLOTS) a = SLOTS;
      return a;
   endfunction

   // deepest safe read length for the packet a read with this match would hit
   function automatic int read_room(input logic [7:0] match);
      int n;
      n = head;
      for (int i = 0; i < SLOTS && n < SLOTS; i++) begin
         if (slot_st[n] != SL_OCCUPIED) break;
         if (bytes[n*SLOT_BYTES] == match) return slot_written[n];
         n = slot_next[n];
      end
      return SLOT_BYTES;
   endfunction

   task automatic add_beat(input status_type st, input logic [7:0] d, input logic l,
                           input int s, input int sl);
      pool_beat_t b;
      int f, fr;
      f = 0;
      fr = 0;
      for (int i = 0; i < active_n(); i++) begin
         if (slot_st[i] == SL_OCCUPIED) f++;
         if (slot_st[i] == SL_FREE) fr++;
      end
      b.status = st;
      b.data   = d;
      b.last   = l;
      b.slot   = s[3:0];
      b.slen   = sl[6:0];
      b.filled = f[4:0];
      b.freec  = fr[4:0];
      b.ready  = (head < SLOTS) && (slot_st[head[3:0]] == SL_OCCUPIED);
      b.flen   = b.ready ? slot_length[head[3:0]][6:0] : 7'd0;
      expected_beats.push_back(b);
   endtask

   task automatic unlink_slot(input int idx);
      int n;
      n = head;
      if (head == idx) begin
         head = slot_next[idx];
      end else begin
         for (int i = 0; i < SLOTS && n < SLOTS; i++) begin
            if (slot_next[n] == idx) begin
               slot_next[n] = slot_next[idx];
               break;
            end
            n = slot_next[n];
         end
      end
      slot_next[idx] = NIL;
   endtask

   task automatic append_slot(input int idx);
      int n;
      n = head;
      slot_next[idx] = NIL;
      if (head >= SLOTS) begin
         head = idx[4:0];
      end else begin
         for (int i = 0; i < SLOTS; i++) begin
            if (slot_next[n] >= SLOTS) begin
               slot_next[n] = idx[4:0];
               break;
            end
            n = slot_next[n];
         end
      end
   endtask

   task automatic predict_push(input logic [7:0] d, input logic l);
      int i;
      status_type st;
      st = ST_OK;
      if (mode == MODE_DROP) begin
         if (l) mode = MODE_IDLE;
         add_beat(ST_NO_FREE, 0, 1, 0, 0);
         return;
      end
      if (mode == MODE_IDLE) begin
         for (i = 0; i < active_n(); i++)
            if (slot_st[i] == SL_FREE) break;
         if (i >= active_n()) begin
            if (!l) mode = MODE_DROP;
            add_beat(ST_NO_FREE, 0, 1, 0, 0);
            return;
         end
         append_slot(i);
         slot_st[i] = SL_FILLING;
         cur_slot = i;
         cursor = 0;
         mode = MODE_FILL;
      end
      if (cursor < SLOT_BYTES) begin
         bytes[cur_slot*SLOT_BYTES + cursor] = d;
         cursor++;
         if (cursor > slot_written[cur_slot]) slot_written[cur_slot] = cursor;
      end else begin
         st = ST_BAD_LEN;
      end
      if (l) begin
         slot_st[cur_slot] = SL_OCCUPIED;
         slot_length[cur_slot] = cursor;
         mode = MODE_IDLE;
         cursor = 0;
      end
      add_beat(st, 0, 1, cur_slot, 0);
   endtask

   task automatic predict_read(input logic [7:0] m, input int len);
      int n, hit, sl;
      n = head;
      hit = SLOTS;
      if (len == 0 || len > SLOT_BYTES) begin
         add_beat(ST_BAD_LEN, 0, 1, 0, 0);
         return;
      end
      for (int i = 0; i < SLOTS && n < SLOTS; i++) begin
         if (slot_st[n] != SL_OCCUPIED) break;
         if (bytes[n*SLOT_BYTES] == m) begin
            hit = n;
            break;
         end
         n = slot_next[n];
      end
      if (hit >= SLOTS) begin
         add_beat(ST_NO_MATCH, 0, 1, 0, 0);
         return;
      end
      sl = slot_length[hit];
      unlink_slot(hit);
      slot_st[hit] = SL_FREE;
      slot_length[hit] = 0;
      for (int i = 0; i < len; i++)
         add_beat(ST_OK, bytes[hit*SLOT_BYTES + i], i + 1 == len, hit, sl);
   endtask

   task automatic predict_free(input int idx);
      if (idx >= active_n()) begin
         add_beat(ST_BAD_SLOT, 0, 1, 0, 0);
         return;
      end
      if (slot_st[idx] != SL_FREE) begin
         unlink_slot(idx);
         slot_st[idx] = SL_FREE;
         slot_length[idx] = 0;
         if (mode == MODE_FILL && cur_slot == idx) begin
            mode = MODE_DROP;
            cursor = 0;
         end
      end
      add_beat(ST_OK, 0, 1, idx, 0);
   endtask

   always @(posedge clock) begin
      pool_beat_t e, g;
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            slot_st[i] = SL_FREE;
            slot_next[i] = NIL;
            slot_length[i] = 0;
            slot_written[i] = 0;
         end
         head = NIL;
         cur_slot = 0;
         cursor = 0;
         mode = MODE_IDLE;
         pool_en = 1'b0;
         active_cfg = 5'd16;
         errors = 0;
         beats_checked = 0;
         expected_beats.delete();
      end else begin
         if (csr_write_enable) begin
            if (csr_index == CSR_ENABLE) pool_en = csr_write_data[0];
            else active_cfg = csr_write_data;
         end
         if (req_valid && !req_stall) begin
            if (!pool_en) add_beat(ST_DISABLED, 0, 1, 0, 0);
            else case (req_code_type'(req_type))
               REQ_PUSH: predict_push(req_data_byte, req_last_byte);
               REQ_READ: predict_read(req_match_byte, req_read_length);
               REQ_FREE: predict_free(req_slot_index);
               default:  add_beat(ST_OK, 0, 1, 0, 0);
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            g = {rsp_status, rsp_data_out, rsp_last, rsp_slot_out, rsp_stored_length,
                 rsp_filled_count, rsp_free_count, rsp_first_ready, rsp_first_length};
            beats_checked++;
            if (expected_beats.size() == 0) begin
               errors++;
               if (errors <= 10) $display("unexpected result beat %h", g);
            end else begin
               e = expected_beats.pop_front();
               if (e.status !== g.status || e.data !== g.data || e.last !== g.last ||
                   e.slot !== g.slot || e.slen !== g.slen || e.filled !== g.filled ||
                   e.freec !== g.freec || e.ready !== g.ready || e.flen !== g.flen) begin
                  errors++;
                  if (errors <= 10)
                     $display({"mismatch: exp st=%0d d=%h l=%b s=%0d sl=%0d f=%0d fr=%0d",
                               " r=%b fl=%0d / got st=%0d d=%h l=%b s=%0d sl=%0d f=%0d",
                               " fr=%0d r=%b fl=%0d"},
                              e.status, e.data, e.last, e.slot, e.slen, e.filled, e.freec,
                              e.ready, e.flen, g.status, g.data, g.last, g.slot, g.slen,
                              g.filled, g.freec, g.ready, g.flen);
               end
            end
         end
      end
   end
endmodule

/* bench/ordered_packet_buffer_pool_top_tb.sv */
// testbench top: stimulus, idling and verdict for the ordered packet buffer pool
module ordered_packet_buffer_pool_top_tb;
   import opbp_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_write_enable = 1'b0;
   logic [0:0] csr_index = '0;
   logic [4:0] csr_write_data = '0;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [1:0] req_type = '0;
   logic [7:0] req_data_byte = '0;
   logic       req_last_byte = 1'b0;
   logic [7:0] req_match_byte = '0;
   logic [6:0] req_read_length = '0;
   logic [3:0] req_slot_index = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [2:0] rsp_status;
   logic [7:0] rsp_data_out;
   logic       rsp_last;
   logic [3:0] rsp_slot_out;
   logic [6:0] rsp_stored_length;
   logic [4:0] rsp_filled_count;
   logic [4:0] rsp_free_count;
   logic       rsp_first_ready;
   logic [6:0] rsp_first_length;

   int errors, pending, beats_checked;
   int tx_idle_pct = 0;
   int rx_stall_pct = 0;
   int hold_cycles = 0;
   int items_sent = 0;
   int quiet_cycles = 0;
   logic [7:0] tags[4] = '{8'h00, 8'hFF, 8'h3C, 8'hA5};

   ordered_packet_buffer_pool_top u_dut (.*);

   ordered_packet_buffer_pool_checker u_chk (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // receiver stall at random, plus a long hold-off while hold_cycles counts down
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < rx_stall_pct);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 20000) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic send(input req_code_type t, input logic [7:0] d, input logic l,
                       input logic [7:0] m, input logic [6:0] rl, input logic [3:0] s);
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_type = t;
      req_data_byte = d;
      req_last_byte = l;
      req_match_byte = m;
      req_read_length = rl;
      req_slot_index = s;
      req_valid = 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic push_packet(input logic [7:0] first, input int n);
      for (int i = 0; i < n; i++)
         send(REQ_PUSH, i == 0 ? first : 8'($urandom), i == n - 1, 8'($urandom),
              7'($urandom), 4'($urandom));
   endtask

   task automatic read_packet(input logic [7:0] m);
      int room;
      room = u_chk.read_room(m);
      send(REQ_READ, 8'($urandom), 1'($urandom), m,
           7'($urandom_range(1, room)), 4'($urandom));
   endtask

   task automatic drain();
      req_valid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   task automatic csr_write(input logic [0:0] idx, input logic [4:0] v);
      csr_write_enable = 1'b1;
      csr_index = idx;
      csr_write_data = v;
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   task automatic random_items(input int count);
      int stop, r;
      logic [7:0] tag;
      stop = items_sent + count;
      while (items_sent < stop) begin
         r = $urandom_range(0, 99);
         tag = ($urandom_range(0, 9) < 8) ? tags[$urandom_range(0, 3)] : 8'($urandom);
         if (r < 45)
            push_packet(tag, ($urandom_range(0, 19) == 0) ? $urandom_range(62, 68)
                                                         : $urandom_range(1, 5));
         else if (r < 72) read_packet(tag);
         else if (r < 82)
            send(REQ_FREE, 8'($urandom), 1'($urandom), 8'($urandom), 7'($urandom),
                 4'($urandom));
         else if (r < 88)
            send(REQ_STATUS, 8'($urandom), 1'($urandom), 8'($urandom), 7'($urandom),
                 4'($urandom));
         else if (r < 94)
            send(REQ_READ, 8'($urandom), 1'($urandom), 8'($urandom),
                 ($urandom_range(0, 1) ? 7'd0 : 7'($urandom_range(65, 127))), 4'($urandom));
         else
            send(REQ_PUSH, 8'($urandom), 1'($urandom), 8'($urandom), 7'($urandom),
                 4'($urandom));
      end
   endtask

   initial begin
      repeat (10) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      // disabled pool, then directed cases
      send(REQ_PUSH, 8'hFF, 1'b1, 8'hFF, 7'd64, 4'd15);
      drain();
      csr_write(CSR_ENABLE, 5'd1);
      csr_write(CSR_ACTIVE, 5'd16);
      push_packet(8'hAA, 3);
      send(REQ_PUSH, 8'h55, 1'b1, 8'h00, 7'd1, 4'd0);
      send(REQ_STATUS, 8'h00, 1'b0, 8'h00, 7'd0, 4'd0);
      send(REQ_READ, 8'h00, 1'b0, 8'h55, 7'd1, 4'd0);
      send(REQ_READ, 8'h00, 1'b0, 8'h77, 7'd1, 4'd0);
      send(REQ_READ, 8'h00, 1'b0, 8'hAA, 7'd0, 4'd0);
      send(REQ_READ, 8'h00, 1'b0, 8'hAA, 7'd65, 4'd0);
      send(REQ_READ, 8'h00, 1'b0, 8'hAA, 7'd127, 4'd0);
      send(REQ_FREE, 8'h00, 1'b0, 8'h00, 7'd0, 4'd15);
      send(REQ_PUSH, 8'h00, 1'b0, 8'h00, 7'd0, 4'd0);
      send(REQ_FREE, 8'h00, 1'b0, 8'h00, 7'd0, 4'd1);
      send(REQ_PUSH, 8'h12, 1'b0, 8'h00, 7'd0, 4'd0);
      send(REQ_PUSH, 8'h34, 1'b1, 8'h00, 7'd0, 4'd0);
      send(REQ_READ, 8'h00, 1'b0, 8'hAA, 7'd3, 4'd0);
      drain();
      csr_write(CSR_ACTIVE, 5'd1);
      send(REQ_PUSH, 8'hFF, 1'b1, 8'h00, 7'd0, 4'd0);
      send(REQ_PUSH, 8'h01, 1'b0, 8'h00, 7'd0, 4'd0);
      send(REQ_PUSH, 8'h02, 1'b1, 8'h00, 7'd0, 4'd0);
      send(REQ_FREE, 8'h00, 1'b0, 8'h00, 7'd0, 4'd5);
      send(REQ_READ, 8'h00, 1'b0, 8'hFF, 7'd1, 4'd0);

      // random phases across settings and idling
      drain();
      csr_write(CSR_ACTIVE, 5'd16);
      random_items(16);
      drain();
      tx_idle_pct = 48;
      csr_write(CSR_ACTIVE, 5'd3);
      random_items(20);
      drain();
      tx_idle_pct = 0;
      rx_stall_pct = 48;
      csr_write(CSR_ACTIVE, 5'd0);
      random_items(12);
      drain();
      csr_write(CSR_ENABLE, 5'd0);
      random_items(6);
      drain();
      tx_idle_pct = 26;
      rx_stall_pct = 26;
      csr_write(CSR_ENABLE, 5'd1);
      csr_write(CSR_ACTIVE, 5'd31);
      random_items(20);

      // long receiver hold-off while requests keep coming
      tx_idle_pct = 0;
      rx_stall_pct = 0;
      hold_cycles = 400;
      for (int i = 0; i < 12; i++) send(REQ_STATUS, 0, 0, 0, 0, 0);
      req_valid = 1'b0;
      while (pending != 0) @(negedge clock);
      random_items(6);

      drain();
      $display("covered %0d requests and %0d result beats over six pool settings",
               items_sent, beats_checked);
      if (errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("%0d mismatches", errors);
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule

/* filelist.f */
rtl/opbp_pkg.sv
rtl/opbp_ram.sv
rtl/opbp_ctrl.sv
rtl/ordered_packet_buffer_pool_top.sv
bench/ordered_packet_buffer_pool_checker.sv
bench/ordered_packet_buffer_pool_top_tb.sv
